// ===== rtl/core/stack_vm_instruction_executor_unit_defines.svh =====
// Assertion macros used by the checker.
`ifndef STACK_VM_INSTRUCTION_EXECUTOR_UNIT_DEFINES_SVH
`define STACK_VM_INSTRUCTION_EXECUTOR_UNIT_DEFINES_SVH

// Same-cycle implication.
`define SVM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("svm check failed");

// Next-cycle implication.
`define SVM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("svm check failed");

`endif

// ===== rtl/core/svm_pkg.sv =====
package svm_pkg;

  localparam int unsigned RAM_WORDS_DEF = 32768;
  localparam int unsigned WORD_BITS_DEF = 16;

  localparam int unsigned SUM_W        = 17;
  localparam int unsigned SHADOW_WORDS = 5;
  localparam int unsigned FRAME_WORDS  = 5;
  localparam int unsigned CALL_MARGIN  = 6;
  localparam int unsigned POINTER_BASE = 3;
  localparam int unsigned TEMP_BASE    = 5;
  localparam int unsigned SCRATCH_FRM  = 13;
  localparam int unsigned SCRATCH_RET  = 14;
  localparam int unsigned BOOT_SP      = 256;
  localparam int unsigned PC_MAX       = 32767;

  typedef enum logic [4:0] {
    FN_PUSH   = 5'd0,
    FN_POP    = 5'd1,
    FN_LABEL  = 5'd2,
    FN_GOTO   = 5'd3,
    FN_IFGOTO = 5'd4,
    FN_FUNC   = 5'd5,
    FN_CALL   = 5'd6,
    FN_RETURN = 5'd7,
    FN_ADD    = 5'd8,
    FN_SUB    = 5'd9,
    FN_NEG    = 5'd10,
    FN_EQ     = 5'd11,
    FN_GT     = 5'd12,
    FN_LT     = 5'd13,
    FN_AND    = 5'd14,
    FN_OR     = 5'd15,
    FN_NOT    = 5'd16
  } func_e;

  typedef enum logic [2:0] {
    SEG_CONST = 3'd0,
    SEG_LOCAL = 3'd1,
    SEG_ARG   = 3'd2,
    SEG_THIS  = 3'd3,
    SEG_THAT  = 3'd4,
    SEG_PTR   = 3'd5,
    SEG_TEMP  = 3'd6,
    SEG_STAT  = 3'd7
  } seg_e;

  typedef enum logic [2:0] {
    STS_OK    = 3'd0,
    STS_PC    = 3'd1,
    STS_UNDER = 3'd2,
    STS_OVER  = 3'd3,
    STS_ADDR  = 3'd4,
    STS_CALL  = 3'd5,
    STS_RET   = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    CFG_START_PC = 2'd0,
    CFG_PROG_LEN = 2'd1,
    CFG_BOOT     = 2'd2
  } cfg_e;

  typedef struct packed {
    logic [4:0]  func;
    logic [2:0]  segment;
    logic [14:0] index;
    logic [14:0] target;
    logic [7:0]  static_base;
  } in_req_t;

  typedef struct packed {
    logic [14:0] next_pc;
    logic [2:0]  status;
    logic [15:0] stack_pointer;
    logic [15:0] top_value;
    logic [31:0] executed_count;
  } out_req_t;

endpackage

// ===== rtl/core/svm_ram.sv =====
module svm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/svm_alu.sv =====
module svm_alu #(
  parameter int unsigned WIDTH = 16
) (
  input  logic [4:0]       func_i,
  input  logic [WIDTH-1:0] x_i,
  input  logic [WIDTH-1:0] y_i,
  output logic [WIDTH-1:0] v_o
);

  always_comb begin
    case (svm_pkg::func_e'(func_i))
      svm_pkg::FN_ADD: v_o = x_i + y_i;
      svm_pkg::FN_SUB: v_o = x_i - y_i;
      svm_pkg::FN_NEG: v_o = '0 - x_i;
      svm_pkg::FN_NOT: v_o = ~x_i;
      svm_pkg::FN_EQ:  v_o = (x_i == y_i) ? '1 : '0;
      svm_pkg::FN_GT:  v_o = ($signed(x_i) > $signed(y_i)) ? '1 : '0;
      svm_pkg::FN_LT:  v_o = ($signed(x_i) < $signed(y_i)) ? '1 : '0;
      svm_pkg::FN_AND: v_o = x_i & y_i;
      svm_pkg::FN_OR:  v_o = x_i | y_i;
      default:         v_o = x_i | y_i;
    endcase
  end

endmodule

// ===== rtl/core/stack_vm_instruction_executor_unit.sv =====
// Path per request: label/goto/errors go straight to the top-of-stack read; push constant writes sp
// then data; other push reads the source first; pop and if-goto pop one word, neg/not pop one and
// binary ops two, then push; call saves the frame; return restores it; function zeroes each local.
// Flow: one request in flight; a new request is taken only back in idle after the result is
// registered, and a finished result may wait in the output register. One word RAM access per cycle.
// Reset: clears the word RAM word by word (no requests taken meanwhile), pc, count 0.
module stack_vm_instruction_executor_unit #(
  parameter int unsigned RAM_WORDS = svm_pkg::RAM_WORDS_DEF,
  parameter int unsigned WORD_BITS = svm_pkg::WORD_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  svm_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output svm_pkg::out_req_t out_req_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [14:0]       cfg_wdata_i
);

  localparam int unsigned AW = $clog2(RAM_WORDS);
  localparam int unsigned SW = svm_pkg::SUM_W;
  localparam logic [SW-1:0] RW = SW'(RAM_WORDS);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DEC, S_RD_A, S_RD_V, S_PUSH_W, S_PUSH_D,
    S_POP_W, S_POP_R, S_POP_V, S_STORE, S_FN_W, S_FN_SP,
    S_CALL_SP, S_CALL_PC, S_CALL_SV, S_CALL_ARG, S_CALL_LCL,
    S_RET_RD, S_RET_13, S_RET_14, S_RET_ST, S_RET_SP, S_RET_RR, S_RET_RW,
    S_TOP, S_TOPV
  } state_e;

  typedef enum logic [2:0] {
    K_STORE, K_IFG, K_UNARY, K_BIN_Y, K_BIN_X, K_RET
  } cont_e;

  state_e               state_q, state_d;
  cont_e                cont_q, cont_d;
  svm_pkg::in_req_t     req_q, req_d;
  svm_pkg::status_e     sts_q, sts_d;
  svm_pkg::out_req_t    out_q, out_d;
  logic                 out_valid_q, out_valid_d;
  logic [14:0]          pc_q, pc_d, npc_q, npc_d, len_q, len_d;
  logic [31:0]          cnt_q, cnt_d;
  logic                 boot_q, boot_d;
  logic [WORD_BITS-1:0] sh_q [svm_pkg::SHADOW_WORDS];
  logic [SW-1:0]        a_q, a_d;
  logic [WORD_BITS-1:0] s_q, s_d, v_q, v_d, y_q, y_d, frm_q, frm_d, ret_q, ret_d;
  logic [14:0]          k_q, k_d;
  logic [2:0]           rk_q, rk_d, rsel_q, rsel_d;
  logic                 rsh_q, rsh_d, top_ok_q, top_ok_d;
  logic [AW-1:0]        clr_q, clr_d;

  logic                 we, re;
  logic [SW-1:0]        wa, ra;
  logic [WORD_BITS-1:0] wd, ram_rd, rv, alu_v, base;
  logic [SW-1:0]        sp, seg_a;
  logic                 seg_ok, pop1, pop2;

  svm_ram #(.WIDTH(WORD_BITS), .DEPTH(RAM_WORDS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wa[AW-1:0]),
    .wdata_i (wd),
    .re_i    (re),
    .raddr_i (ra[AW-1:0]),
    .rdata_o (ram_rd)
  );

  svm_alu #(.WIDTH(WORD_BITS)) u_alu (
    .func_i (req_q.func),
    .x_i    (rv),
    .y_i    (y_q),
    .v_o    (alu_v)
  );

  // words 0..4 live in flops as well; reads there come from the shadow
  assign rv = rsh_q ? sh_q[rsel_q] : ram_rd;
  assign sp = SW'(sh_q[0]);
  assign pop1 = (sp >= SW'(1)) && (sp <= RW);
  assign pop2 = (sp >= SW'(2)) && (sp <= RW);

  always_comb begin
    case (svm_pkg::seg_e'(req_q.segment))
      svm_pkg::SEG_LOCAL: base = sh_q[1];
      svm_pkg::SEG_ARG:   base = sh_q[2];
      svm_pkg::SEG_THIS:  base = sh_q[3];
      svm_pkg::SEG_THAT:  base = sh_q[4];
      svm_pkg::SEG_PTR:   base = WORD_BITS'(svm_pkg::POINTER_BASE);
      svm_pkg::SEG_TEMP:  base = WORD_BITS'(svm_pkg::TEMP_BASE);
      svm_pkg::SEG_STAT:  base = WORD_BITS'(req_q.static_base);
      default:            base = '0;
    endcase
  end

  assign seg_a  = SW'(base) + SW'(req_q.index);
  assign seg_ok = (req_q.segment != svm_pkg::SEG_CONST) && (seg_a < RW);

  always_comb begin
    state_d = state_q;  cont_d = cont_q;  req_d = req_q;  sts_d = sts_q;
    out_d = out_q;  out_valid_d = out_valid_q;  pc_d = pc_q;  npc_d = npc_q;
    len_d = len_q;  cnt_d = cnt_q;  boot_d = boot_q;  a_d = a_q;  s_d = s_q;
    v_d = v_q;  y_d = y_q;  frm_d = frm_q;  ret_d = ret_q;  k_d = k_q;  rk_d = rk_q;
    rsel_d = rsel_q;  rsh_d = rsh_q;  top_ok_d = top_ok_q;  clr_d = clr_q;
    we = 1'b0;  wa = '0;  wd = '0;  re = 1'b0;  ra = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        we = 1'b1;  wa = SW'(clr_q);
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(RAM_WORDS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (boot_q) begin
          we = 1'b1;  wd = WORD_BITS'(svm_pkg::BOOT_SP);
          boot_d = 1'b0;
        end else if (in_valid_i) begin
          req_d = in_req_i;  sts_d = svm_pkg::STS_OK;  state_d = S_DEC;
        end
      end
      S_DEC: begin
        npc_d = pc_q + 15'd1;
        state_d = S_TOP;
        if (pc_q >= len_q) begin
          sts_d = svm_pkg::STS_PC;
        end else begin
          case (svm_pkg::func_e'(req_q.func))
            svm_pkg::FN_PUSH: begin
              if (req_q.segment == svm_pkg::SEG_CONST) begin
                if (sp >= RW) sts_d = svm_pkg::STS_OVER;
                else begin
                  v_d = WORD_BITS'(req_q.index);  state_d = S_PUSH_W;
                end
              end else if (!seg_ok) sts_d = svm_pkg::STS_ADDR;
              else if (sp >= RW) sts_d = svm_pkg::STS_OVER;
              else begin
                a_d = seg_a;  state_d = S_RD_A;
              end
            end
            svm_pkg::FN_POP: begin
              if (!seg_ok) sts_d = svm_pkg::STS_ADDR;
              else if (!pop1) sts_d = svm_pkg::STS_UNDER;
              else begin
                a_d = seg_a;  cont_d = K_STORE;  state_d = S_POP_W;
              end
            end
            svm_pkg::FN_GOTO: npc_d = req_q.target;
            svm_pkg::FN_IFGOTO: begin
              if (!pop1) sts_d = svm_pkg::STS_UNDER;
              else begin
                cont_d = K_IFG;  state_d = S_POP_W;
              end
            end
            svm_pkg::FN_FUNC: begin
              if (req_q.index != '0) begin
                if (sp + SW'(req_q.index) > RW) sts_d = svm_pkg::STS_OVER;
                else begin
                  s_d = sh_q[0];  k_d = '0;  state_d = S_FN_W;
                end
              end
            end
            svm_pkg::FN_CALL: begin
              if (sp < SW'(req_q.index) || sp > RW - SW'(svm_pkg::CALL_MARGIN)) begin
                sts_d = svm_pkg::STS_CALL;
              end else begin
                s_d = sh_q[0];  state_d = S_CALL_SP;
              end
            end
            svm_pkg::FN_RETURN: begin
              if (SW'(sh_q[1]) < SW'(svm_pkg::FRAME_WORDS) || SW'(sh_q[1]) >= RW ||
                  SW'(sh_q[2]) >= RW) begin
                sts_d = svm_pkg::STS_RET;
              end else if (!pop1) sts_d = svm_pkg::STS_UNDER;
              else begin
                frm_d = sh_q[1];  state_d = S_RET_RD;
              end
            end
            svm_pkg::FN_NEG, svm_pkg::FN_NOT: begin
              if (!pop1) sts_d = svm_pkg::STS_UNDER;
              else begin
                cont_d = K_UNARY;  state_d = S_POP_W;
              end
            end
            svm_pkg::FN_ADD, svm_pkg::FN_SUB, svm_pkg::FN_EQ, svm_pkg::FN_GT,
            svm_pkg::FN_LT, svm_pkg::FN_AND, svm_pkg::FN_OR: begin
              if (!pop2) sts_d = svm_pkg::STS_UNDER;
              else begin
                cont_d = K_BIN_Y;  state_d = S_POP_W;
              end
            end
            default: state_d = S_TOP;
          endcase
        end
      end
      S_RD_A: begin
        re = 1'b1;  ra = a_q;  state_d = S_RD_V;
      end
      S_RD_V: begin
        v_d = rv;  state_d = S_PUSH_W;
      end
      S_PUSH_W: begin
        s_d = sh_q[0];
        we = 1'b1;  wd = sh_q[0] + WORD_BITS'(1);
        state_d = S_PUSH_D;
      end
      S_PUSH_D: begin
        we = 1'b1;  wa = SW'(s_q);  wd = v_q;  state_d = S_TOP;
      end
      S_POP_W: begin
        s_d = sh_q[0] - WORD_BITS'(1);
        we = 1'b1;  wd = sh_q[0] - WORD_BITS'(1);
        state_d = S_POP_R;
      end
      S_POP_R: begin
        re = 1'b1;  ra = SW'(s_q);  state_d = S_POP_V;
      end
      S_POP_V: begin
        v_d = rv;
        case (cont_q)
          K_STORE: state_d = S_STORE;
          K_IFG: begin
            if (rv != '0) npc_d = req_q.target;
            state_d = S_TOP;
          end
          K_UNARY: begin
            v_d = alu_v;  state_d = S_PUSH_W;
          end
          K_BIN_Y: begin
            y_d = rv;  cont_d = K_BIN_X;  state_d = S_POP_W;
          end
          K_BIN_X: begin
            v_d = alu_v;  state_d = S_PUSH_W;
          end
          K_RET: state_d = S_RET_ST;
          default: state_d = S_TOP;
        endcase
      end
      S_STORE: begin
        we = 1'b1;  wa = a_q;  wd = v_q;  state_d = S_TOP;
      end
      S_FN_W: begin
        we = 1'b1;  wa = SW'(s_q) + SW'(k_q);
        k_d = k_q + 15'd1;
        if (k_q + 15'd1 == req_q.index) state_d = S_FN_SP;
      end
      S_FN_SP: begin
        we = 1'b1;  wd = s_q + WORD_BITS'(req_q.index);  state_d = S_TOP;
      end
      S_CALL_SP: begin
        we = 1'b1;  wd = s_q + WORD_BITS'(svm_pkg::FRAME_WORDS);  state_d = S_CALL_PC;
      end
      S_CALL_PC: begin
        we = 1'b1;  wa = SW'(s_q);  wd = WORD_BITS'(pc_q) + WORD_BITS'(1);
        k_d = 15'd1;  state_d = S_CALL_SV;
      end
      S_CALL_SV: begin
        we = 1'b1;  wa = SW'(s_q) + SW'(k_q);  wd = sh_q[k_q[2:0]];
        k_d = k_q + 15'd1;
        if (k_q == 15'd4) state_d = S_CALL_ARG;
      end
      S_CALL_ARG: begin
        we = 1'b1;  wa = SW'(2);  wd = s_q - WORD_BITS'(req_q.index);
        state_d = S_CALL_LCL;
      end
      S_CALL_LCL: begin
        we = 1'b1;  wa = SW'(1);  wd = s_q + WORD_BITS'(svm_pkg::FRAME_WORDS);
        npc_d = req_q.target;  state_d = S_TOP;
      end
      S_RET_RD: begin
        re = 1'b1;  ra = SW'(frm_q) - SW'(svm_pkg::FRAME_WORDS);  state_d = S_RET_13;
      end
      S_RET_13: begin
        ret_d = rv;
        we = 1'b1;  wa = SW'(svm_pkg::SCRATCH_FRM);  wd = frm_q;  state_d = S_RET_14;
      end
      S_RET_14: begin
        we = 1'b1;  wa = SW'(svm_pkg::SCRATCH_RET);  wd = ret_q;
        cont_d = K_RET;  state_d = S_POP_W;
      end
      S_RET_ST: begin
        we = 1'b1;  wa = SW'(sh_q[2]);  wd = v_q;  state_d = S_RET_SP;
      end
      S_RET_SP: begin
        we = 1'b1;  wd = sh_q[2] + WORD_BITS'(1);
        rk_d = 3'd4;  state_d = S_RET_RR;
      end
      S_RET_RR: begin
        re = 1'b1;
        ra = SW'(frm_q) - SW'(svm_pkg::FRAME_WORDS) + SW'(rk_q);
        state_d = S_RET_RW;
      end
      S_RET_RW: begin
        we = 1'b1;  wa = SW'(rk_q);  wd = rv;
        rk_d = rk_q - 3'd1;
        if (rk_q == 3'd1) begin
          npc_d = (ret_q > WORD_BITS'(svm_pkg::PC_MAX)) ? 15'(svm_pkg::PC_MAX) : ret_q[14:0];
          state_d = S_TOP;
        end else begin
          state_d = S_RET_RR;
        end
      end
      S_TOP: begin
        top_ok_d = pop1;
        if (pop1) begin
          re = 1'b1;  ra = sp - SW'(1);
        end
        state_d = S_TOPV;
      end
      S_TOPV: begin
        if (!(out_valid_q && out_stall_i)) begin
          out_d.status = sts_q;
          out_d.stack_pointer = sh_q[0];
          out_d.top_value = top_ok_q ? rv : '0;
          if (sts_q == svm_pkg::STS_OK) begin
            pc_d = npc_q;  cnt_d = cnt_q + 32'd1;
            out_d.next_pc = npc_q;  out_d.executed_count = cnt_q + 32'd1;
          end else begin
            out_d.next_pc = pc_q;  out_d.executed_count = cnt_q;
          end
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (re) begin
      rsh_d = ra < SW'(svm_pkg::SHADOW_WORDS);
      rsel_d = ra[2:0];
    end

    if (cfg_we_i) begin
      case (svm_pkg::cfg_e'(cfg_idx_i))
        svm_pkg::CFG_START_PC: pc_d = cfg_wdata_i;
        svm_pkg::CFG_PROG_LEN: len_d = cfg_wdata_i;
        svm_pkg::CFG_BOOT: if (cfg_wdata_i[0]) boot_d = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cont_q <= K_STORE;
      sts_q <= svm_pkg::STS_OK;
      out_valid_q <= 1'b0;
      pc_q <= '0;
      len_q <= 15'd1;
      cnt_q <= '0;
      boot_q <= 1'b0;
      clr_q <= '0;
      rsh_q <= 1'b0;
      rsel_q <= '0;
      top_ok_q <= 1'b0;
      for (int i = 0; i < svm_pkg::SHADOW_WORDS; i++) begin
        sh_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      cont_q <= cont_d;
      sts_q <= sts_d;
      out_valid_q <= out_valid_d;
      pc_q <= pc_d;
      len_q <= len_d;
      cnt_q <= cnt_d;
      boot_q <= boot_d;
      clr_q <= clr_d;
      rsh_q <= rsh_d;
      rsel_q <= rsel_d;
      top_ok_q <= top_ok_d;
      if (we && wa < SW'(svm_pkg::SHADOW_WORDS)) begin
        sh_q[wa[2:0]] <= wd;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;  out_q <= out_d;  npc_q <= npc_d;  a_q <= a_d;  s_q <= s_d;
    v_q <= v_d;  y_q <= y_d;  frm_q <= frm_d;  ret_q <= ret_d;  k_q <= k_d;  rk_q <= rk_d;
  end

  assign in_stall_o  = !(state_q == S_IDLE && !boot_q);
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

// ===== rtl/core/svm_checker.sv =====
`include "stack_vm_instruction_executor_unit_defines.svh"

module svm_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input svm_pkg::out_req_t out_req_o
);

  `SVM_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_req_o))
  `SVM_ASSERT_NOW(a_status_range, out_valid_o, out_req_o.status <= svm_pkg::STS_RET)
  `SVM_ASSERT_NEXT(a_busy_after_req, in_valid_i && !in_stall_o, in_stall_o)
  `SVM_ASSERT_NEXT(a_one_result, in_valid_i && !in_stall_o, !(out_valid_o && !$past(out_valid_o) && !in_stall_o))

endmodule

bind stack_vm_instruction_executor_unit svm_checker u_svm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_req_o   (out_req_o)
);
